/* sv/psch_pkg.sv */
// shared types, codes and constants of the priority task scheduler
// no dependencies; psch_cfg_regs and priority_task_scheduler import it

package psch_pkg;

	localparam int MAX_TASKS_DEF  = 4;
	localparam int DELAY_BITS_DEF = 16;

	localparam int TASK_W     = 3;
	localparam int PRIO_W     = 2;
	localparam int DELAY_IN_W = 16;
	localparam int TICK_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 3;
	localparam int PRIO_REGS  = 4;

	// register indexes of the config port
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_BASE  = 3'd1;

	localparam logic [TASK_W-1:0] TASK_COUNT_RST = 3'd3;
	localparam logic [PRIO_W-1:0] PRIO_DEF       = 2'd3;

	function automatic logic [PRIO_W-1:0] prio_rst(input int idx);
		logic [PRIO_W-1:0] val;
		case (idx)
			0:       val = 2'd0;
			1:       val = 2'd2;
			2:       val = 2'd1;
			default: val = PRIO_DEF;
		endcase
		return val;
	endfunction

	// task state codes held in the state memory
	localparam logic [1:0] ST_READY   = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_WAITING = 2'd2;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_DELAY = 1'b1;

	localparam logic [TASK_W-1:0] NO_TASK = 3'd7;

	typedef struct packed {
		logic                  cmd;
		logic [DELAY_IN_W-1:0] delay_ticks;
	} item_t;

	typedef struct packed {
		logic [TASK_W-1:0] sel_task;
		logic              switched;
		logic [TICK_W-1:0] tick_total;
	} result_t;

endpackage

/* sv/psch_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module psch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/psch_cfg_regs.sv */
// configuration registers: task count and per-task priorities
// depends on psch_pkg

module psch_cfg_regs import psch_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [CFG_DATA_W-1:0]                cfg_wdata,
	output logic [TASK_W-1:0]                    task_num,
	output logic [MAX_TASKS-1:0][PRIO_W-1:0]     prio
);

	logic [TASK_W-1:0]                task_count_q;
	logic [MAX_TASKS-1:0][PRIO_W-1:0] prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= TASK_COUNT_RST;
			for (int i = 0; i < MAX_TASKS; i++) begin
				prio_q[i] <= prio_rst(i);
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_TASK_COUNT) begin
				task_count_q <= cfg_wdata[TASK_W-1:0];
			end
			for (int i = 0; i < MAX_TASKS; i++) begin
				if (i < PRIO_REGS && 32'(cfg_index) == 32'(CFG_PRIO_BASE) + 32'(i)) begin
					prio_q[i] <= cfg_wdata[PRIO_W-1:0];
				end
			end
		end
	end

	// effective count: zero acts as one, clamp at the task capacity
	always_comb begin
		if (task_count_q == '0) begin
			task_num = TASK_W'(1);
		end else if (32'(task_count_q) > MAX_TASKS) begin
			task_num = TASK_W'(MAX_TASKS);
		end else begin
			task_num = task_count_q;
		end
	end

	assign prio = prio_q;

endmodule

/* sv/priority_task_scheduler.sv */
// top level of the fixed-priority preemptive task scheduler
// depends on psch_pkg, psch_ram, psch_cfg_regs

// A command (tick or delay) is taken when start is high and busy is low. The
// block walks the task memories one entry per cycle, counting down waiting
// tasks on a tick and picking the best-priority runnable task, then commits
// the switch. A delay first marks the running task waiting in S_DELAY; both
// commands then pass S_SCAN, S_REL and S_RUN, which registers done. The result
// beat is on result for exactly one cycle with done high, and the receiver
// cannot stall it: it must take the beat in that cycle. A new command may be
// started in the cycle the done strobe is shown. The user must make config
// writes only while busy is low; the block does not enforce it. Memory entries
// never written read as ready / zero through per-entry valid flops, so no
// clearing pass is needed after reset.

module priority_task_scheduler import psch_pkg::*; #(
	parameter int MAX_TASKS  = MAX_TASKS_DEF,
	parameter int DELAY_BITS = DELAY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// result side
	output logic                  done,
	output result_t               result
);

	// address widths of the state memory (idle slot included) and counter memory
	localparam int SAW = $clog2(MAX_TASKS + 1);
	localparam int CAW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int WIDE_W = (DELAY_BITS > DELAY_IN_W) ? DELAY_BITS : DELAY_IN_W;
	localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_DELAY,
		S_SCAN,
		S_REL,
		S_RUN
	} state_t;

	state_t state_q;

	// config
	logic [TASK_W-1:0]                task_num;
	logic [MAX_TASKS-1:0][PRIO_W-1:0] prio;

	// command registers
	logic                  cmd_q;
	logic [DELAY_IN_W-1:0] delay_q;
	logic [TASK_W-1:0]     running_q;
	logic [TICK_W-1:0]     tick_q;

	// scan pipeline: read issue and, in the cycle after, the returned entry
	logic [TASK_W-1:0] idx_q;
	logic              v_s1;
	logic [TASK_W-1:0] idx_s1;
	logic              sv_s1;
	logic              cv_s1;

	// running best pick of the scan
	logic              found_q;
	logic [TASK_W-1:0] best_q;
	logic [PRIO_W-1:0] best_prio_q;

	// per-entry written flags, unwritten entries read as reset value
	logic [MAX_TASKS:0]   st_valid_q;
	logic [MAX_TASKS-1:0] cnt_valid_q;

	// memory ports
	logic                  st_we;
	logic [SAW-1:0]        st_waddr;
	logic [1:0]            st_wdata;
	logic [SAW-1:0]        st_raddr;
	logic [1:0]            st_rdata;
	logic                  cnt_we;
	logic [CAW-1:0]        cnt_waddr;
	logic [DELAY_BITS-1:0] cnt_wdata;
	logic [CAW-1:0]        cnt_raddr;
	logic [DELAY_BITS-1:0] cnt_rdata;

	// datapath
	logic                  is_delay;
	logic                  run_ok;
	logic                  rel_ok;
	logic [WIDE_W-1:0]     dly_wide;
	logic [DELAY_BITS-1:0] dly_val;
	logic [1:0]            st_cur;
	logic [1:0]            st_new;
	logic [DELAY_BITS-1:0] cnt_cur;
	logic [DELAY_BITS-1:0] cnt_dec;
	logic                  cnt_upd;
	logic                  eligible;
	logic [PRIO_W-1:0]     prio_s1;
	logic                  better;
	logic                  issue;
	logic                  scan_end;
	logic [TASK_W-1:0]     next_sel;
	logic                  sw;

	psch_cfg_regs #(
		.MAX_TASKS(MAX_TASKS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.task_num (task_num),
		.prio     (prio)
	);

	// task state per slot, idle slot included
	psch_ram #(
		.WIDTH(2),
		.DEPTH(MAX_TASKS + 1),
		.AW   (SAW)
	) u_state_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// wait counters of the user tasks
	psch_ram #(
		.WIDTH(DELAY_BITS),
		.DEPTH(MAX_TASKS),
		.AW   (CAW)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	assign is_delay = (cmd_q == CMD_DELAY);
	assign run_ok   = (running_q < task_num);
	assign rel_ok   = !is_delay && (32'(running_q) <= MAX_TASKS);

	// delay value: zero counts as one, saturate to the counter width
	always_comb begin
		dly_wide = WIDE_W'(delay_q);
		if (dly_wide == '0) begin
			dly_val = DELAY_BITS'(1);
		end else if (dly_wide > WIDE_W'(DELAY_MAX)) begin
			dly_val = DELAY_MAX;
		end else begin
			dly_val = DELAY_BITS'(dly_wide);
		end
	end

	// entry returned by the memories this cycle
	assign st_cur  = sv_s1 ? st_rdata : ST_READY;
	assign cnt_cur = cv_s1 ? cnt_rdata : '0;
	assign cnt_dec = cnt_cur - DELAY_BITS'(1);
	assign cnt_upd = v_s1 && !is_delay && (st_cur == ST_WAITING);
	assign st_new  = (cnt_upd && cnt_dec == '0) ? ST_READY : st_cur;
	assign eligible = (st_new != ST_WAITING);
	assign prio_s1 = prio[idx_s1[CAW-1:0]];
	assign better  = v_s1 && eligible && (!found_q || prio_s1 < best_prio_q);

	assign issue    = (state_q == S_SCAN) && (idx_q < task_num);
	assign scan_end = (idx_q == task_num) && !v_s1;
	assign st_raddr = SAW'(idx_q);
	assign cnt_raddr = CAW'(idx_q);

	assign next_sel = found_q ? best_q : task_num;
	assign sw       = (next_sel != running_q);

	// write-back mux: one writer per state
	always_comb begin
		st_we     = 1'b0;
		st_waddr  = '0;
		st_wdata  = ST_READY;
		cnt_we    = 1'b0;
		cnt_waddr = '0;
		cnt_wdata = '0;
		unique case (state_q)
			S_DELAY: begin
				if (run_ok) begin
					st_we     = 1'b1;
					st_waddr  = SAW'(running_q);
					st_wdata  = ST_WAITING;
					cnt_we    = 1'b1;
					cnt_waddr = CAW'(running_q);
					cnt_wdata = dly_val;
				end
			end
			S_SCAN: begin
				if (cnt_upd) begin
					cnt_we    = 1'b1;
					cnt_waddr = CAW'(idx_s1);
					cnt_wdata = cnt_dec;
					if (cnt_dec == '0) begin
						st_we    = 1'b1;
						st_waddr = SAW'(idx_s1);
						st_wdata = ST_READY;
					end
				end
			end
			S_REL: begin
				// preempted task goes back to ready on a tick
				if (sw && rel_ok) begin
					st_we    = 1'b1;
					st_waddr = SAW'(running_q);
					st_wdata = ST_READY;
				end
			end
			S_RUN: begin
				if (sw) begin
					st_we    = 1'b1;
					st_waddr = SAW'(next_sel);
					st_wdata = ST_RUNNING;
				end
			end
			default: begin
			end
		endcase
	end

	// valid flags and scan pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_valid_q  <= '0;
			cnt_valid_q <= '0;
			v_s1        <= 1'b0;
		end else begin
			if (st_we) begin
				st_valid_q[st_waddr] <= 1'b1;
			end
			if (cnt_we) begin
				cnt_valid_q[cnt_waddr] <= 1'b1;
			end
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		sv_s1  <= st_valid_q[st_raddr];
		cv_s1  <= cnt_valid_q[cnt_raddr];
	end

	// sequencer with registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= NO_TASK;
			tick_q      <= '0;
			cmd_q       <= CMD_TICK;
			delay_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_prio_q <= '0;
			done        <= 1'b0;
			result      <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= item.cmd;
						delay_q <= item.delay_ticks;
						idx_q   <= '0;
						found_q <= 1'b0;
						if (item.cmd == CMD_TICK) begin
							tick_q <= tick_q + TICK_W'(1);
						end
						state_q <= (item.cmd == CMD_DELAY) ? S_DELAY : S_SCAN;
					end
				end
				S_DELAY: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + TASK_W'(1);
					end
					if (better) begin
						found_q     <= 1'b1;
						best_q      <= idx_s1;
						best_prio_q <= prio_s1;
					end
					if (scan_end) begin
						state_q <= S_REL;
					end
				end
				S_REL: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (sw) begin
						running_q <= next_sel;
					end
					done              <= 1'b1;
					result.sel_task   <= next_sel;
					result.switched   <= sw;
					result.tick_total <= tick_q;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
